// ===== hdl/tiafd_pkg.sv =====
package tiafd_pkg;

    localparam int QueueDepthDefault = 4;

    localparam logic [4:0] OP_ADD    = 5'd0;
    localparam logic [4:0] OP_SUB    = 5'd1;
    localparam logic [4:0] OP_MUL    = 5'd2;
    localparam logic [4:0] OP_MIN    = 5'd3;
    localparam logic [4:0] OP_MAX    = 5'd4;
    localparam logic [4:0] OP_EQ     = 5'd5;
    localparam logic [4:0] OP_NE     = 5'd6;
    localparam logic [4:0] OP_LT     = 5'd7;
    localparam logic [4:0] OP_LE     = 5'd8;
    localparam logic [4:0] OP_GT     = 5'd9;
    localparam logic [4:0] OP_GE     = 5'd10;
    localparam logic [4:0] OP_DIV    = 5'd11;
    localparam logic [4:0] OP_MOD    = 5'd12;
    localparam logic [4:0] OP_AND    = 5'd13;
    localparam logic [4:0] OP_OR     = 5'd14;
    localparam logic [4:0] OP_XOR    = 5'd15;
    localparam logic [4:0] OP_NOT    = 5'd16;
    localparam logic [4:0] OP_SHL    = 5'd17;
    localparam logic [4:0] OP_SHR    = 5'd18;
    localparam logic [4:0] OP_ABS    = 5'd19;
    localparam logic [4:0] OP_ABSD   = 5'd20;
    localparam logic [4:0] OP_MASK   = 5'd21;
    localparam logic [4:0] OP_SELECT = 5'd22;
    localparam logic [4:0] OP_MULADD = 5'd23;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic        sgn;
        logic [6:0]  w;
        logic        is_div;
    } t_item;

    function automatic logic [63:0] width_mask(input logic [6:0] w);
        logic [63:0] m;
        if (w >= 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << w[5:0]) - 64'd1;
        end
        return m;
    endfunction

    function automatic logic [63:0] wrap_to(input logic [63:0] x, input logic [6:0] w,
                                            input logic sgn);
        logic [63:0] m;
        logic [63:0] r;
        logic [5:0]  top;
        m   = width_mask(w);
        top = 6'(w - 7'd1);
        r   = x & m;
        if (sgn && (w < 7'd64) && r[top]) begin
            r = r | ~m;
        end
        return r;
    endfunction

endpackage

// ===== hdl/tiafd_front.sv =====
module tiafd_front
    import tiafd_pkg::*;
(
    input  logic        i_start,
    input  logic        i_full,
    input  logic [4:0]  i_command,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic [63:0] i_operand_c,
    input  logic        i_is_signed,
    input  logic [6:0]  i_elem_width,
    output logic        o_push,
    output t_item       o_item
);

    logic [6:0] w;

    always_comb begin
        if (i_elem_width == 7'd0) begin
            w = 7'd1;
        end else if (i_elem_width > 7'd64) begin
            w = 7'd64;
        end else begin
            w = i_elem_width;
        end
    end

    assign o_push        = i_start & ~i_full;
    assign o_item.cmd    = i_command;
    assign o_item.a      = wrap_to(i_operand_a, w, i_is_signed);
    assign o_item.b      = wrap_to(i_operand_b, w, i_is_signed);
    assign o_item.c      = wrap_to(i_operand_c, w, i_is_signed);
    assign o_item.sgn    = i_is_signed;
    assign o_item.w      = w;
    assign o_item.is_div = (i_command == OP_DIV) || (i_command == OP_MOD);

endmodule

// ===== hdl/tiafd_queue.sv =====
module tiafd_queue
    import tiafd_pkg::*;
#(
    parameter int DEPTH = QueueDepthDefault
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic              do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/tiafd_back.sv =====
module tiafd_back
    import tiafd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    output logic [63:0] o_result_bits
);

    // divider
    logic        r_div_busy;
    logic        r_div_fin;
    logic [5:0]  r_div_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_my;
    logic [63:0] r_y;
    logic        r_xn;
    logic        r_yn;
    logic        r_dsgn;
    logic        r_want_rem;
    logic        r_zero;
    logic [6:0]  r_dw;

    // stage 1
    logic        r_s1_valid;
    logic        r_s1_mul;
    logic [63:0] r_s1_res;
    logic [63:0] r_s1_pll;
    logic [31:0] r_s1_plh;
    logic [31:0] r_s1_phl;
    logic [63:0] r_s1_c;
    logic        r_s1_sgn;
    logic [6:0]  r_s1_w;

    logic        r_out_valid;
    logic [63:0] r_out_res;

    logic        can_take;
    logic        take_div;
    logic        take_op;
    logic [64:0] rem_sh;
    logic        rem_ge;
    logic [63:0] n_rem;
    logic [63:0] div_res;
    logic [63:0] simple_res;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] amt;
    logic        amt_big;
    logic        a_lt_b;
    logic        b_lt_a;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic        sgn;
    logic [63:0] n_mul_sum;
    logic [63:0] n_out;

    assign can_take = ~r_div_busy & ~r_div_fin;
    assign o_pop    = can_take & i_valid;
    assign take_div = o_pop & i_item.is_div;
    assign take_op  = o_pop & ~i_item.is_div;

    assign a   = i_item.a;
    assign b   = i_item.b;
    assign c   = i_item.c;
    assign sgn = i_item.sgn;

    assign a_lt_b = sgn ? ((a ^ 64'h8000_0000_0000_0000) < (b ^ 64'h8000_0000_0000_0000))
                        : (a < b);
    assign b_lt_a = sgn ? ((b ^ 64'h8000_0000_0000_0000) < (a ^ 64'h8000_0000_0000_0000))
                        : (b < a);
    assign amt     = b & width_mask(i_item.w);
    assign amt_big = (amt >= {57'd0, i_item.w});
    assign mx      = (sgn && a[63]) ? (64'd0 - a) : a;
    assign my      = (sgn && b[63]) ? (64'd0 - b) : b;

    always_comb begin
        case (i_item.cmd)
            OP_ADD:    simple_res = a + b;
            OP_SUB:    simple_res = a - b;
            OP_MIN:    simple_res = b_lt_a ? b : a;
            OP_MAX:    simple_res = a_lt_b ? b : a;
            OP_EQ:     simple_res = {63'd0, a == b};
            OP_NE:     simple_res = {63'd0, a != b};
            OP_LT:     simple_res = {63'd0, a_lt_b};
            OP_LE:     simple_res = {63'd0, ~b_lt_a};
            OP_GT:     simple_res = {63'd0, b_lt_a};
            OP_GE:     simple_res = {63'd0, ~a_lt_b};
            OP_AND:    simple_res = a & b;
            OP_OR:     simple_res = a | b;
            OP_XOR:    simple_res = a ^ b;
            OP_NOT:    simple_res = ~a;
            OP_SHL:    simple_res = amt_big ? 64'd0 : (a << amt[5:0]);
            OP_SHR: begin
                if (amt_big) begin
                    simple_res = (sgn && a[63]) ? '1 : 64'd0;
                end else if (sgn) begin
                    simple_res = 64'($signed(a) >>> amt[5:0]);
                end else begin
                    simple_res = a >> amt[5:0];
                end
            end
            OP_ABS:    simple_res = (sgn && a[63]) ? (64'd0 - a) : a;
            OP_ABSD:   simple_res = a_lt_b ? (b - a) : (a - b);
            OP_MASK:   simple_res = (a != 64'd0) ? '1 : 64'd0;
            OP_SELECT: simple_res = (a != 64'd0) ? b : c;
            default:   simple_res = 64'd0;
        endcase
    end

    assign rem_sh = {r_rem, r_quo[63]};
    assign rem_ge = (rem_sh >= {1'b0, r_my});
    assign n_rem  = rem_ge ? 64'(rem_sh - {1'b0, r_my}) : rem_sh[63:0];

    always_comb begin
        if (r_zero) begin
            div_res = 64'd0;
        end else if (!r_dsgn) begin
            div_res = r_want_rem ? r_rem : r_quo;
        end else if (r_want_rem) begin
            if ((r_rem != 64'd0) && (r_xn != r_yn)) begin
                div_res = r_xn ? (r_y - r_rem) : (r_y + r_rem);
            end else begin
                div_res = r_xn ? (64'd0 - r_rem) : r_rem;
            end
        end else if (r_xn != r_yn) begin
            div_res = (r_rem != 64'd0) ? ~r_quo : (64'd0 - r_quo);
        end else begin
            div_res = r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_fin  <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            r_div_fin <= 1'b0;
            if (take_div) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= '0;
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == '1) begin
                    r_div_busy <= 1'b0;
                    r_div_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_div) begin
            r_rem      <= 64'd0;
            r_quo      <= mx;
            r_my       <= my;
            r_y        <= b;
            r_xn       <= sgn & a[63];
            r_yn       <= sgn & b[63];
            r_dsgn     <= sgn;
            r_want_rem <= (i_item.cmd == OP_MOD);
            r_zero     <= (b == 64'd0);
            r_dw       <= i_item.w;
        end else if (r_div_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[62:0], rem_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= take_op | r_div_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_div_fin) begin
            r_s1_mul <= 1'b0;
            r_s1_res <= div_res;
            r_s1_sgn <= r_dsgn;
            r_s1_w   <= r_dw;
        end else begin
            r_s1_mul <= (i_item.cmd == OP_MUL) || (i_item.cmd == OP_MULADD);
            r_s1_res <= simple_res;
            r_s1_sgn <= sgn;
            r_s1_w   <= i_item.w;
        end
        r_s1_pll <= a[31:0] * b[31:0];
        r_s1_plh <= 32'(a[31:0] * b[63:32]);
        r_s1_phl <= 32'(a[63:32] * b[31:0]);
        r_s1_c   <= (i_item.cmd == OP_MULADD) ? c : 64'd0;
    end

    assign n_mul_sum = r_s1_pll + {r_s1_plh + r_s1_phl, 32'd0} + r_s1_c;
    assign n_out     = wrap_to(r_s1_mul ? n_mul_sum : r_s1_res, r_s1_w, r_s1_sgn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_res <= n_out;
    end

    assign o_valid       = r_out_valid;
    assign o_result_bits = r_out_res;

`ifndef SYNTHESIS
    a_no_pop_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_busy || r_div_fin) |-> !o_pop)
        else $error("transfer taken while divider holds an item");
    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_div |=> r_div_busy && r_div_cnt == '0)
        else $error("divider did not start");
    a_fin_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_div_fin) |-> $past(r_div_busy))
        else $error("divider finish without run");
    a_fin_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_fin |=> r_s1_valid ##1 r_out_valid)
        else $error("divide result lost");
`endif

endmodule

// ===== hdl/typed_integer_alu_floor_divide_unit.sv =====
// all ops but div and mod: an item passes through the queue, stage 1 and the output register to o_valid
// div and mod: the radix-2 divider takes 64 steps between the queue and stage 1
// throughput: one item per cycle while no div or mod holds the back end
// busy rises when the QUEUE_DEPTH-entry queue (4 by default) between front and back end is full
// synchronous active-low reset clears queue, divider and strobe pipeline
module typed_integer_alu_floor_divide_unit
    import tiafd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  i_command,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic [63:0] i_operand_c,
    input  logic        i_is_signed,
    input  logic [6:0]  i_elem_width,
    output logic        o_valid,
    output logic [63:0] o_result_bits
);

    logic  push;
    logic  full;
    logic  head_valid;
    logic  pop;
    t_item in_item;
    t_item head_item;

    assign busy = full;

    tiafd_front u_front (
        .i_start      (start),
        .i_full       (full),
        .i_command    (i_command),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .i_operand_c  (i_operand_c),
        .i_is_signed  (i_is_signed),
        .i_elem_width (i_elem_width),
        .o_push       (push),
        .o_item       (in_item)
    );

    tiafd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    tiafd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (head_valid),
        .i_item        (head_item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_result_bits (o_result_bits)
    );

endmodule
